### rtl/core/hlt_pkg.sv
// Shared types and constants for the held lock table.
// Used by hlt_ctrl, hlt_datapath and held_lock_table; no dependencies.
package hlt_pkg;

    localparam int TABLE_DEPTH   = 64;
    localparam int TAG_BITS      = 64;
    localparam int NUM_STRENGTHS = 8;

    localparam int IN_TAG_W   = 64;
    localparam int STRENGTH_W = 4;
    localparam int MODE_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int ENTRY_W    = 7;
    localparam int COUNT_W    = $clog2(TABLE_DEPTH + 1);

    localparam int IN_DATA_W  = ((IN_TAG_W + STRENGTH_W + 7) / 8) * 8;
    localparam int IN_USER_W  = MODE_W + 1;
    localparam int OUT_BITS   = 1 + STRENGTH_W + ENTRY_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int OUT_USER_W = STATUS_W;

    typedef enum logic [MODE_W-1:0] {
        OP_ACQUIRE     = 2'd0,
        OP_RELEASE     = 2'd1,
        OP_RELEASE_ALL = 2'd2,
        OP_QUERY       = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 2'd0,
        ST_NOT_HELD = 2'd1,
        ST_FULL     = 2'd2
    } status_t;

    // capture: request taken, compare against the table this cycle
    // commit:  apply the update and load the result register
    typedef struct packed {
        logic capture;
        logic commit;
    } hlt_cmd_t;

endpackage

### rtl/core/hlt_ctrl.sv
// Controller for the held lock table: two-state sequencer and result valid.
// Depends on hlt_pkg.
module hlt_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output hlt_pkg::hlt_cmd_t cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free    = !out_valid_reg || m_tready;
    assign s_tready    = (state_reg == S_IDLE);
    assign cmd.capture = (state_reg == S_IDLE) && s_tvalid;
    assign cmd.commit  = (state_reg == S_EXEC) && out_free;
    assign m_tvalid    = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### rtl/core/hlt_datapath.sv
// Datapath for the held lock table: slot cells with parallel tag compare,
// update logic, entry counters and the result register. Depends on hlt_pkg.
module hlt_datapath
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  hlt_pkg::hlt_cmd_t                  cmd,
    input  logic [hlt_pkg::IN_DATA_W-1:0]      in_data,
    input  logic [hlt_pkg::IN_USER_W-1:0]      in_user,
    output logic [hlt_pkg::OUT_DATA_W-1:0]     out_data,
    output logic [hlt_pkg::OUT_USER_W-1:0]     out_user
);

    localparam int DEPTH = hlt_pkg::TABLE_DEPTH;
    localparam int TW    = hlt_pkg::TAG_BITS;
    localparam int SW    = hlt_pkg::STRENGTH_W;
    localparam int CW    = hlt_pkg::COUNT_W;
    localparam int NS    = hlt_pkg::NUM_STRENGTHS;

    // slot cells
    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] valid_next;
    logic [TW-1:0]    slot_tag_reg      [DEPTH];
    logic [SW-1:0]    slot_strength_reg [DEPTH];
    logic [DEPTH-1:0] slot_session_reg;

    // session / non-session entry counts
    logic [CW-1:0] sess_cnt_reg;
    logic [CW-1:0] sess_cnt_next;
    logic [CW-1:0] nsess_cnt_reg;
    logic [CW-1:0] nsess_cnt_next;
    logic [CW-1:0] total;
    logic [CW-1:0] total_next;

    // captured request
    hlt_pkg::op_t  req_mode_reg;
    logic [TW-1:0] req_tag_reg;
    logic [SW-1:0] req_strength_reg;
    logic          req_session_reg;

    logic [TW-1:0]    in_tag;
    logic [DEPTH-1:0] tag_hit_next;
    logic [DEPTH-1:0] tag_hit_reg;

    // execute stage
    logic [DEPTH-1:0]      exact_hit;
    logic [NS-1:0]         held;
    logic                  str_ok;
    logic                  found;
    logic                  hit_session;
    logic [DEPTH-1:0]      free_vec;
    logic [DEPTH-1:0]      free_onehot;
    logic                  have_free;
    logic                  write_en;
    hlt_pkg::status_t      status_next;
    logic                  enough_next;
    logic [SW-1:0]         strongest_next;

    // result register
    hlt_pkg::status_t            out_status_reg;
    logic                        out_enough_reg;
    logic [SW-1:0]               out_strongest_reg;
    logic [hlt_pkg::ENTRY_W-1:0] out_count_reg;

    assign in_tag = in_data[TW-1:0];
    assign total  = CW'(sess_cnt_reg + nsess_cnt_reg);

    // compare every cell against the incoming tag in the capture cycle
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            tag_hit_next[i] = valid_reg[i] && (slot_tag_reg[i] == in_tag);
        end
    end

    always_comb
    begin
        held = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            exact_hit[i] = tag_hit_reg[i] && (slot_strength_reg[i] == req_strength_reg);
            for (int s = 0; s < NS; s++)
            begin
                if (tag_hit_reg[i] && slot_strength_reg[i] == SW'(s + 1))
                begin
                    held[s] = 1'b1;
                end
            end
        end
    end

    assign str_ok      = (req_strength_reg != '0) && (req_strength_reg <= SW'(NS));
    assign found       = |exact_hit;
    assign hit_session = |(exact_hit & slot_session_reg);
    assign free_vec    = ~valid_reg;
    assign free_onehot = free_vec & (~free_vec + DEPTH'(1));
    assign have_free   = |free_vec;

    always_comb
    begin
        valid_next     = valid_reg;
        sess_cnt_next  = sess_cnt_reg;
        nsess_cnt_next = nsess_cnt_reg;
        write_en       = 1'b0;
        status_next    = hlt_pkg::ST_DONE;
        enough_next    = 1'b0;
        strongest_next = '0;
        unique case (req_mode_reg)
            hlt_pkg::OP_ACQUIRE:
            begin
                if (str_ok && !found)
                begin
                    if (have_free)
                    begin
                        write_en   = 1'b1;
                        valid_next = valid_reg | free_onehot;
                        if (req_session_reg)
                        begin
                            sess_cnt_next = CW'(sess_cnt_reg + 1'b1);
                        end
                        else
                        begin
                            nsess_cnt_next = CW'(nsess_cnt_reg + 1'b1);
                        end
                    end
                    else
                    begin
                        status_next = hlt_pkg::ST_FULL;
                    end
                end
            end
            hlt_pkg::OP_RELEASE:
            begin
                // entries never hold strength 0 or above the top, so found covers str_ok
                if (found)
                begin
                    valid_next = valid_reg & ~exact_hit;
                    if (hit_session)
                    begin
                        sess_cnt_next = CW'(sess_cnt_reg - 1'b1);
                    end
                    else
                    begin
                        nsess_cnt_next = CW'(nsess_cnt_reg - 1'b1);
                    end
                end
                else
                begin
                    status_next = hlt_pkg::ST_NOT_HELD;
                end
            end
            hlt_pkg::OP_RELEASE_ALL:
            begin
                nsess_cnt_next = '0;
                if (req_session_reg)
                begin
                    valid_next    = '0;
                    sess_cnt_next = '0;
                end
                else
                begin
                    valid_next = valid_reg & slot_session_reg;
                end
            end
            hlt_pkg::OP_QUERY:
            begin
                for (int s = 0; s < NS; s++)
                begin
                    if (held[s])
                    begin
                        strongest_next = SW'(s + 1);
                        if (SW'(s + 1) >= req_strength_reg)
                        begin
                            enough_next = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                status_next = hlt_pkg::ST_DONE;
            end
        endcase
    end

    assign total_next = CW'(sess_cnt_next + nsess_cnt_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            sess_cnt_reg  <= '0;
            nsess_cnt_reg <= '0;
        end
        else if (cmd.commit)
        begin
            valid_reg     <= valid_next;
            sess_cnt_reg  <= sess_cnt_next;
            nsess_cnt_reg <= nsess_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_mode_reg     <= hlt_pkg::op_t'(in_user[hlt_pkg::MODE_W-1:0]);
            req_session_reg  <= in_user[hlt_pkg::MODE_W];
            req_tag_reg      <= in_tag;
            req_strength_reg <= in_data[hlt_pkg::IN_TAG_W +: SW];
            tag_hit_reg      <= tag_hit_next;
        end
        if (cmd.commit)
        begin
            out_status_reg    <= status_next;
            out_enough_reg    <= enough_next;
            out_strongest_reg <= strongest_next;
            out_count_reg     <= hlt_pkg::ENTRY_W'(total_next);
            for (int i = 0; i < DEPTH; i++)
            begin
                if (write_en && free_onehot[i])
                begin
                    slot_tag_reg[i]      <= req_tag_reg;
                    slot_strength_reg[i] <= req_strength_reg;
                    slot_session_reg[i]  <= req_session_reg;
                end
            end
        end
    end

    assign out_user = out_status_reg;
    assign out_data = {(hlt_pkg::OUT_DATA_W - hlt_pkg::OUT_BITS)'(0),
                       out_count_reg, out_strongest_reg, out_enough_reg};

    a_exact_single: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> $onehot0(exact_hit))
        else $error("more than one slot holds the same tag and strength");

    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(total))
        else $error("entry count disagrees with valid slots");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(total) <= DEPTH)
        else $error("entry count above table depth");

    a_release_dec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && req_mode_reg == hlt_pkg::OP_RELEASE && found
        |=> total == CW'($past(total) - 1'b1))
        else $error("release of a held entry did not drop the count");

endmodule

### rtl/core/held_lock_table.sv
// Channel | dir | tdata (low bit up)                  | tuser (low bit up)
// s_*     | in  | lock_tag[63:0], lock_strength[67:64] | mode[1:0], session_flag[2]
// m_*     | out | held_enough[0], strongest_held[4:1], | status[1:0]
//         |     | entry_count[11:5]                    |
//
// Accept step: compare the tag against all 64 slots in parallel. Update step:
// apply the update, load the result; then the next request can be taken.
// A waiting result holds back only the update cycle of the next request.
// Reset clears all valid bits and counts at once; no clearing pass.
// Top level of the held lock table; depends on hlt_pkg, hlt_ctrl, hlt_datapath.
module held_lock_table
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [hlt_pkg::IN_DATA_W-1:0]  s_tdata,   // lock_tag, lock_strength, zero pad
    input  logic [hlt_pkg::IN_USER_W-1:0]  s_tuser,   // mode, session_flag
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [hlt_pkg::OUT_DATA_W-1:0] m_tdata,   // held_enough, strongest_held,
                                                      // entry_count, zero pad
    output logic [hlt_pkg::OUT_USER_W-1:0] m_tuser    // status
);

    hlt_pkg::hlt_cmd_t cmd;

    hlt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    hlt_datapath u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_data  (s_tdata),
        .in_user  (s_tuser),
        .out_data (m_tdata),
        .out_user (m_tuser)
    );

endmodule

### verif/testbench.sv
// Self-checking testbench for held_lock_table: random stream traffic on both sides,
// every result checked against a behavioral copy of the lock table kept here.
// Depends on hlt_pkg and the held_lock_table RTL.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 800;
    localparam logic [63:0] TAG_KEEP = (hlt_pkg::TAG_BITS >= 64) ? {64{1'b1}}
                                     : ((64'd1 << hlt_pkg::TAG_BITS) - 64'd1);

    typedef struct packed {
        hlt_pkg::op_t mode;
        logic [63:0]  tag;
        logic [3:0]   strength;
        logic         session;
    } lock_req_t;

    typedef struct packed {
        hlt_pkg::status_t status;
        logic             held_enough;
        logic [3:0]       strongest;
        logic [6:0]       entry_count;
    } lock_resp_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [hlt_pkg::IN_DATA_W-1:0]  s_tdata = '0;     // lock_tag, lock_strength, zero pad
    logic [hlt_pkg::IN_USER_W-1:0]  s_tuser = '0;     // mode, session_flag
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [hlt_pkg::OUT_DATA_W-1:0] m_tdata;          // held_enough, strongest_held,
                                                      // entry_count, pad
    logic [hlt_pkg::OUT_USER_W-1:0] m_tuser;          // status

    held_lock_table dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // behavioral copy of the table
    bit          held_valid    [hlt_pkg::TABLE_DEPTH];
    logic [63:0] held_tag      [hlt_pkg::TABLE_DEPTH];
    logic [3:0]  held_strength [hlt_pkg::TABLE_DEPTH];
    bit          held_session  [hlt_pkg::TABLE_DEPTH];
    int          held_count = 0;

    lock_req_t   pending_requests[$];
    lock_resp_t  lock_results_due[$];
    logic [63:0] tag_pool[10];
    int          queued = 0;
    int          mismatches = 0;
    int          results_seen = 0;
    int          idle_cycles = 0;
    bit          s_taken = 1'b0;
    bit          s_quiet = 1'b0;
    bit          m_quiet = 1'b0;
    int          s_gap = 0;
    int          m_stall = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic lock_resp_t apply_lock_request(input lock_req_t r);
        lock_resp_t  res;
        logic [63:0] key;
        bit          legal;
        int          hit;
        int          free_slot;
        res = '0;
        res.status = hlt_pkg::ST_DONE;
        key = r.tag & TAG_KEEP;
        legal = (r.strength != 0) && (r.strength <= hlt_pkg::NUM_STRENGTHS);
        hit = -1;
        free_slot = -1;
        for (int i = 0; i < hlt_pkg::TABLE_DEPTH; i++)
        begin
            if (held_valid[i] && held_tag[i] == key && held_strength[i] == r.strength && hit < 0)
                hit = i;
            if (!held_valid[i] && free_slot < 0)
                free_slot = i;
        end
        case (r.mode)
            hlt_pkg::OP_ACQUIRE:
            begin
                // strength 0/out of range and duplicates are silently ignored
                if (legal && hit < 0)
                begin
                    if (free_slot < 0)
                        res.status = hlt_pkg::ST_FULL;
                    else
                    begin
                        held_valid[free_slot]    = 1'b1;
                        held_tag[free_slot]      = key;
                        held_strength[free_slot] = r.strength;
                        held_session[free_slot]  = r.session;
                        held_count++;
                    end
                end
            end
            hlt_pkg::OP_RELEASE:
            begin
                if (!legal || hit < 0)
                    res.status = hlt_pkg::ST_NOT_HELD;
                else
                begin
                    held_valid[hit] = 1'b0;
                    held_count--;
                end
            end
            hlt_pkg::OP_RELEASE_ALL:
            begin
                for (int i = 0; i < hlt_pkg::TABLE_DEPTH; i++)
                begin
                    if (held_valid[i] && (r.session || !held_session[i]))
                    begin
                        held_valid[i] = 1'b0;
                        held_count--;
                    end
                end
            end
            default:
            begin
                for (int i = 0; i < hlt_pkg::TABLE_DEPTH; i++)
                begin
                    if (held_valid[i] && held_tag[i] == key)
                    begin
                        if (held_strength[i] > res.strongest)
                            res.strongest = held_strength[i];
                        if (held_strength[i] >= r.strength)
                            res.held_enough = 1'b1;
                    end
                end
            end
        endcase
        res.entry_count = held_count[6:0];
        return res;
    endfunction

    task automatic queue_request(input hlt_pkg::op_t mode, input logic [63:0] tag,
                                 input logic [3:0] strength, input logic session);
        lock_req_t r;
        r.mode = mode;
        r.tag = tag;
        r.strength = strength;
        r.session = session;
        pending_requests = {pending_requests, r};
        queued++;
    endtask

    // more distinct pairs than slots, so the table reports full near the end
    task automatic queue_fill_burst();
        int n;
        n = hlt_pkg::TABLE_DEPTH + 2 + $urandom_range(0, 8);
        repeat (n)
            queue_request(hlt_pkg::OP_ACQUIRE, {$urandom, $urandom},
                          4'($urandom_range(1, 8)), 1'($urandom_range(0, 1)));
        repeat (3)
            queue_request(hlt_pkg::OP_QUERY, tag_pool[$urandom_range(0, 9)],
                          4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
        queue_request(hlt_pkg::OP_RELEASE, tag_pool[$urandom_range(0, 9)],
                      4'($urandom_range(1, 8)), 1'b0);
        queue_request(hlt_pkg::OP_RELEASE_ALL, {$urandom, $urandom},
                      4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
    endtask

    function automatic int pick_gap(input bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t ERROR: %s", $realtime, msg);
    endtask

    // request driver
    always @(negedge clk)
    begin : request_driver
        lock_req_t nxt;
        if ($urandom_range(0, 199) == 0)
            s_quiet = !s_quiet;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (s_tvalid && !s_taken)
            ;   // hold until taken
        else if (s_gap > 0)
        begin
            s_tvalid <= 1'b0;
            s_gap--;
        end
        else if (pending_requests.size() > 0)
        begin
            nxt = pending_requests.pop_front();
            s_tvalid <= 1'b1;
            s_tdata <= {{(hlt_pkg::IN_DATA_W - hlt_pkg::IN_TAG_W - hlt_pkg::STRENGTH_W){1'b0}},
                        nxt.strength, nxt.tag};
            s_tuser <= {nxt.session, nxt.mode};
            s_gap = pick_gap(s_quiet);
        end
        else
            s_tvalid <= 1'b0;
    end

    // result back-pressure
    always @(negedge clk)
    begin
        if ($urandom_range(0, 199) == 0)
            m_quiet = !m_quiet;
        if (!rst_n)
            m_tready <= 1'b0;
        else if (m_stall > 0)
        begin
            m_tready <= 1'b0;
            m_stall--;
        end
        else
        begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 2) == 0)
                m_stall = pick_gap(m_quiet);
        end
    end

    // result checker and request predictor
    always @(posedge clk)
    begin : result_monitor
        lock_req_t  req;
        lock_resp_t got;
        lock_resp_t want;
        if (!rst_n)
            s_taken <= 1'b0;
        else
        begin
            s_taken <= s_tvalid && s_tready;
            if (m_tvalid && m_tready)
            begin
                got.status      = hlt_pkg::status_t'(m_tuser);
                got.held_enough = m_tdata[0];
                got.strongest   = m_tdata[4:1];
                got.entry_count = m_tdata[11:5];
                if (lock_results_due.size() == 0)
                    report_mismatch($sformatf({"unexpected result status %0d enough %0d ",
                                               "strongest %0d count %0d"},
                                              got.status, got.held_enough, got.strongest,
                                              got.entry_count));
                else
                begin
                    want = lock_results_due.pop_front();
                    if (got.status !== want.status || got.held_enough !== want.held_enough ||
                        got.strongest !== want.strongest || got.entry_count !== want.entry_count)
                        report_mismatch($sformatf({"result %0d: expected status %0d enough %0d ",
                                                   "strongest %0d count %0d, got status %0d ",
                                                   "enough %0d strongest %0d count %0d"},
                                                  results_seen, want.status, want.held_enough,
                                                  want.strongest, want.entry_count, got.status,
                                                  got.held_enough, got.strongest, got.entry_count));
                end
                results_seen++;
            end
            if (s_tvalid && s_tready)
            begin
                req.mode     = hlt_pkg::op_t'(s_tuser[1:0]);
                req.session  = s_tuser[2];
                req.tag      = s_tdata[63:0];
                req.strength = s_tdata[67:64];
                lock_results_due = {lock_results_due, apply_lock_request(req)};
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("held_lock_table verification failed");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        logic [63:0] ones;
        logic [63:0] tg;
        logic [3:0]  st;
        int          r;
        ones = {64{1'b1}};
        tag_pool[0] = '0;
        tag_pool[1] = ones;
        for (int i = 2; i < 10; i++)
            tag_pool[i] = {$urandom, $urandom};

        // directed: empty table, field extremes, ignored and rejected requests
        queue_request(hlt_pkg::OP_QUERY,       ones, 4'd0,  1'b0);
        queue_request(hlt_pkg::OP_RELEASE,     '0,   4'd1,  1'b0);
        queue_request(hlt_pkg::OP_ACQUIRE,     ones, 4'd8,  1'b1);
        queue_request(hlt_pkg::OP_ACQUIRE,     ones, 4'd8,  1'b0);   // duplicate pair
        queue_request(hlt_pkg::OP_ACQUIRE,     '0,   4'd1,  1'b0);
        queue_request(hlt_pkg::OP_ACQUIRE,     '0,   4'd0,  1'b1);   // no strength
        queue_request(hlt_pkg::OP_ACQUIRE,     '0,   4'd9,  1'b0);   // beyond strongest
        queue_request(hlt_pkg::OP_ACQUIRE,     '0,   4'd15, 1'b1);
        queue_request(hlt_pkg::OP_ACQUIRE,     ones, 4'd3,  1'b0);
        queue_request(hlt_pkg::OP_QUERY,       ones, 4'd0,  1'b1);
        queue_request(hlt_pkg::OP_QUERY,       ones, 4'd8,  1'b0);
        queue_request(hlt_pkg::OP_QUERY,       ones, 4'd9,  1'b0);
        queue_request(hlt_pkg::OP_QUERY,       ones, 4'd15, 1'b0);
        queue_request(hlt_pkg::OP_QUERY,       '0,   4'd2,  1'b0);
        queue_request(hlt_pkg::OP_RELEASE,     '0,   4'd0,  1'b0);
        queue_request(hlt_pkg::OP_RELEASE,     '0,   4'd12, 1'b1);
        queue_request(hlt_pkg::OP_RELEASE,     ones, 4'd3,  1'b0);
        queue_request(hlt_pkg::OP_RELEASE,     ones, 4'd3,  1'b0);   // already gone
        queue_request(hlt_pkg::OP_QUERY,       64'h5555_5555_5555_5555, 4'd1, 1'b0);
        queue_request(hlt_pkg::OP_ACQUIRE,     64'hAAAA_AAAA_AAAA_AAAA, 4'd5, 1'b1);
        queue_request(hlt_pkg::OP_RELEASE_ALL, '0,   4'd0,  1'b0);   // keeps session locks
        queue_request(hlt_pkg::OP_QUERY,       ones, 4'd8,  1'b0);
        queue_request(hlt_pkg::OP_RELEASE_ALL, ones, 4'd15, 1'b1);   // drops everything
        queue_request(hlt_pkg::OP_QUERY,       ones, 4'd1,  1'b0);

        queue_fill_burst();
        while (queued < RANDOM_ITEMS + 24)
        begin
            if ($urandom_range(0, 7) == 0)
                queue_fill_burst();
            else
                repeat (20)
                begin
                    tg = ($urandom_range(0, 99) < 75) ? tag_pool[$urandom_range(0, 9)]
                                                      : {$urandom, $urandom};
                    st = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(1, 8))
                                                      : 4'($urandom_range(0, 15));
                    r = $urandom_range(0, 99);
                    if (r < 42)
                        queue_request(hlt_pkg::OP_ACQUIRE, tg, st, 1'($urandom_range(0, 1)));
                    else if (r < 67)
                        queue_request(hlt_pkg::OP_RELEASE, tg, st, 1'($urandom_range(0, 1)));
                    else if (r < 97)
                        queue_request(hlt_pkg::OP_QUERY, tg, st, 1'($urandom_range(0, 1)));
                    else
                        queue_request(hlt_pkg::OP_RELEASE_ALL, tg, st,
                                      1'($urandom_range(0, 1)));
                end
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_requests.size() != 0 || s_tvalid || lock_results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("held_lock_table verification clean");
        else
            $display("held_lock_table verification failed");
        $finish;
    end

endmodule
